/* src/bvmp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bvmp_pkg;

  localparam int BANK_BYTES_DEF   = 8192;
  localparam int NUM_BANKS_DEF    = 32;
  localparam int WINDOW_BYTES_DEF = 4096;

  localparam int OFFSET_W = 13;
  localparam int DATA_W   = 8;
  localparam int BANK_SEL_W = 5;
  localparam int CIDX_W   = 11;
  localparam int BANK_TABLE = 32;
  localparam int WRAP_STEPS = 5;

  localparam int VREG_PAL_BIT = 7;
  localparam int VREG_NMI_BIT = 5;
  localparam int PAIR_BLACK_BIT = 15;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [1:0] {
    REG_VIDEO = 2'd0,
    REG_PEN   = 2'd1,
    REG_BG    = 2'd2,
    REG_WIN   = 2'd3
  } region_t;

  typedef struct packed {
    logic                  acc;
    logic                  wr;
    region_t               region;
    logic [OFFSET_W-1:0]   offset;
    logic [DATA_W-1:0]     wdata;
    logic                  pal_sel;
    logic [BANK_SEL_W-1:0] bank_sel;
    logic [DATA_W-1:0]     pen;
  } mem_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] pix;
    logic [DATA_W-1:0] tile;
    logic [DATA_W-1:0] pal_even;
    logic [DATA_W-1:0] pal_odd;
  } mem_rd_t;

  // 5-bit channel to 8 bits: replicate the top bits into the low end
  function automatic logic [DATA_W-1:0] expand5(logic [4:0] x);
    return {x, x[4:2]};
  endfunction

  // offset modulo m for m no smaller than 1/32 of the offset range
  function automatic logic [OFFSET_W-1:0] wrap_offset(logic [OFFSET_W-1:0] v, int m);
    logic [OFFSET_W-1:0] r;
    r = v;
    for (int s = WRAP_STEPS - 1; s >= 0; s--) begin
      if (int'(r) >= (m << s)) begin
        r = r - OFFSET_W'(m << s);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/bvmp_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
module bvmp_mem
  import bvmp_pkg::*;
#(
  parameter int BANK_BYTES   = BANK_BYTES_DEF,
  parameter int NUM_BANKS    = NUM_BANKS_DEF,
  parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mem_req_t req,
  output mem_rd_t       rd,
  output logic          clr_busy
);

  localparam int OFF_W    = $clog2(BANK_BYTES);
  localparam int BANK_W   = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int BG_DEPTH = NUM_BANKS * (2 ** OFF_W);
  localparam int BG_AW    = $clog2(BG_DEPTH);
  localparam int WIN_AW   = $clog2(WINDOW_BYTES);
  localparam int PAL_ROWS = (WINDOW_BYTES + 1) / 2;
  localparam int ROW_W    = (PAL_ROWS > 1) ? $clog2(PAL_ROWS) : 1;

  logic [DATA_W-1:0] bg_pix_mem [BG_DEPTH];
  logic [DATA_W-1:0] bg_pen_mem [BG_DEPTH];
  logic [DATA_W-1:0] tile_mem   [WINDOW_BYTES];
  logic [DATA_W-1:0] pal_even_mem [PAL_ROWS];
  logic [DATA_W-1:0] pal_odd_mem  [PAL_ROWS];

  logic [BANK_W-1:0] bank;
  logic [OFF_W-1:0]  bg_off;
  logic [BG_AW-1:0]  bg_addr;
  logic [WIN_AW-1:0] win_a;
  logic [ROW_W-1:0]  row;
  logic              bg_we;
  logic              tile_we;
  logic              pal_we;
  logic              even_we;
  logic              odd_we;
  logic [ROW_W-1:0]  pal_wa;
  logic [DATA_W-1:0] pal_wd;
  logic [DATA_W-1:0] pen_wd;

  logic [DATA_W-1:0] pix_rd_r;
  logic [DATA_W-1:0] tile_rd_r;
  logic [DATA_W-1:0] even_rd_r;
  logic [DATA_W-1:0] odd_rd_r;

  logic              clr_busy_r;
  logic              clr_busy_nxt;
  logic [ROW_W-1:0]  clr_cnt_r;
  logic [ROW_W-1:0]  clr_cnt_nxt;

  always_comb begin
    bank = '0;
    for (int i = 0; i < BANK_TABLE; i++) begin
      if (req.bank_sel == BANK_SEL_W'(i)) begin
        bank = BANK_W'(i % NUM_BANKS);
      end
    end
  end

  always_comb begin
    bg_off  = OFF_W'(wrap_offset(req.offset, BANK_BYTES));
    bg_addr = BG_AW'({bank, bg_off});
    win_a   = WIN_AW'(wrap_offset(req.offset, WINDOW_BYTES));
    row     = ROW_W'(win_a >> 1);
    bg_we   = req.acc && (req.wr == CMD_WRITE) && (req.region == REG_BG);
    tile_we = req.acc && (req.wr == CMD_WRITE) && (req.region == REG_WIN) && !req.pal_sel;
    pal_we  = req.acc && (req.wr == CMD_WRITE) && (req.region == REG_WIN) && req.pal_sel;
    even_we = clr_busy_r || (pal_we && !win_a[0]);
    odd_we  = clr_busy_r || (pal_we && win_a[0]);
    pal_wa  = clr_busy_r ? clr_cnt_r : row;
    pal_wd  = clr_busy_r ? '0 : req.wdata;
    pen_wd  = (req.wdata != '0) ? req.pen : '0;
  end

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == ROW_W'(PAL_ROWS - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (bg_we) begin
      bg_pix_mem[bg_addr] <= req.wdata;
    end
    if (req.acc) begin
      pix_rd_r <= bg_pix_mem[bg_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (bg_we) begin
      bg_pen_mem[bg_addr] <= pen_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (tile_we) begin
      tile_mem[win_a] <= req.wdata;
    end
    if (req.acc) begin
      tile_rd_r <= tile_mem[win_a];
    end
  end

  always_ff @(posedge clk) begin
    if (even_we) begin
      pal_even_mem[pal_wa] <= pal_wd;
    end
    if (req.acc) begin
      even_rd_r <= pal_even_mem[row];
    end
  end

  always_ff @(posedge clk) begin
    if (odd_we) begin
      pal_odd_mem[pal_wa] <= pal_wd;
    end
    if (req.acc) begin
      odd_rd_r <= pal_odd_mem[row];
    end
  end

  assign rd       = {pix_rd_r, tile_rd_r, even_rd_r, odd_rd_r};
  assign clr_busy = clr_busy_r;

endmodule
`default_nettype wire

/* src/banked_video_memory_port.sv */
// Banked video memory port: CPU side of the video board.
// Input channel (in_*): one bus access per transfer. in_cmd selects read or
// write, in_region the target (video register, pen latch, background RAM,
// foreground/palette window), in_offset the byte, in_wdata the write data.
// Result channel (out_*): exactly one result per access, in order: read
// data, a palette color update (index and 8-bit red/green/blue) and the NMI
// pulse flag for video register writes with bit 5 set.
// An access moves through the middle stage and then the result register.
// One access is taken every cycle while in_stall is low; the memories are
// single-ported per plane, and a palette write reads its partner byte from
// the other half of the split palette RAM. Reset clears the video register,
// pen latch and pipeline, then sweeps the palette RAM to zero, one byte pair
// per cycle over (WINDOW_BYTES+1)/2 pairs, 2048 at the default size, during
// which in_stall stays high. When out_stall is high the result register
// holds, the middle stage fills, and in_stall rises once both are occupied.
`timescale 1ns / 1ps
`default_nettype none
module banked_video_memory_port
  import bvmp_pkg::*;
#(
  parameter int BANK_BYTES   = BANK_BYTES_DEF,
  parameter int NUM_BANKS    = NUM_BANKS_DEF,
  parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_cmd,
  input  wire logic [1:0]          in_region,
  input  wire logic [OFFSET_W-1:0] in_offset,
  input  wire logic [DATA_W-1:0]   in_wdata,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [DATA_W-1:0]        out_rdata,
  output logic                     out_color_valid,
  output logic [CIDX_W-1:0]        out_color_index,
  output logic [DATA_W-1:0]        out_red,
  output logic [DATA_W-1:0]        out_green,
  output logic [DATA_W-1:0]        out_blue,
  output logic                     out_nmi_pulse
);

  mem_req_t          req;
  mem_rd_t           rd;
  logic              clr_busy;
  logic              acc;
  logic              out_adv;
  logic [OFFSET_W-1:0] win_off;

  logic [DATA_W-1:0] video_reg_r;
  logic [DATA_W-1:0] pen_latch_r;

  logic              s1_v_r;
  logic              s1_v_nxt;
  logic              s1_wr_r;
  region_t           s1_region_r;
  logic              s1_pal_r;
  logic              s1_lsb_r;
  logic [CIDX_W-1:0] s1_idx_r;
  logic [DATA_W-1:0] s1_wdata_r;
  logic [DATA_W-1:0] s1_vreg_r;
  logic              s1_nmi_r;

  logic              out_v_r;
  logic              out_v_nxt;
  logic [DATA_W-1:0] rdata_nxt;
  logic              cvalid_nxt;
  logic [15:0]       pair;
  logic [DATA_W-1:0] red_nxt;
  logic [DATA_W-1:0] green_nxt;
  logic [DATA_W-1:0] blue_nxt;
  logic [DATA_W-1:0] rdata_r;
  logic              cvalid_r;
  logic [CIDX_W-1:0] cidx_r;
  logic [DATA_W-1:0] red_r;
  logic [DATA_W-1:0] green_r;
  logic [DATA_W-1:0] blue_r;
  logic              nmi_r;

  assign out_adv  = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = clr_busy || (s1_v_r && !out_adv);
  assign acc      = in_valid && !in_stall;
  assign win_off  = wrap_offset(in_offset, WINDOW_BYTES);

  always_comb begin
    req.acc      = acc;
    req.wr       = in_cmd;
    req.region   = region_t'(in_region);
    req.offset   = in_offset;
    req.wdata    = in_wdata;
    req.pal_sel  = video_reg_r[VREG_PAL_BIT];
    req.bank_sel = video_reg_r[BANK_SEL_W-1:0];
    req.pen      = pen_latch_r;
  end

  bvmp_mem #(
    .BANK_BYTES  (BANK_BYTES),
    .NUM_BANKS   (NUM_BANKS),
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd      (rd),
    .clr_busy(clr_busy)
  );

  // architectural registers update at the input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      video_reg_r <= '0;
      pen_latch_r <= '0;
    end else if (acc && (in_cmd == CMD_WRITE)) begin
      if (region_t'(in_region) == REG_VIDEO) begin
        video_reg_r <= in_wdata;
      end
      if (region_t'(in_region) == REG_PEN) begin
        pen_latch_r <= in_wdata;
      end
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (acc) begin
      s1_v_nxt = 1'b1;
    end else if (out_adv) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (out_adv) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_wr_r     <= in_cmd;
      s1_region_r <= region_t'(in_region);
      s1_pal_r    <= video_reg_r[VREG_PAL_BIT];
      s1_lsb_r    <= win_off[0];
      s1_idx_r    <= CIDX_W'(win_off >> 1);
      s1_wdata_r  <= in_wdata;
      s1_vreg_r   <= video_reg_r;
      s1_nmi_r    <= (in_cmd == CMD_WRITE) && (region_t'(in_region) == REG_VIDEO)
                     && in_wdata[VREG_NMI_BIT];
    end
  end

  always_comb begin
    rdata_nxt  = '0;
    cvalid_nxt = 1'b0;
    case (s1_region_r)
      REG_VIDEO: begin
        if (s1_wr_r == CMD_READ) begin
          rdata_nxt = s1_vreg_r;
        end
      end
      REG_BG: begin
        if (s1_wr_r == CMD_READ) begin
          rdata_nxt = rd.pix;
        end
      end
      REG_WIN: begin
        if (s1_wr_r == CMD_READ) begin
          if (s1_pal_r) begin
            rdata_nxt = s1_lsb_r ? rd.pal_odd : rd.pal_even;
          end else begin
            rdata_nxt = rd.tile;
          end
        end else begin
          cvalid_nxt = s1_pal_r;
        end
      end
      default: begin
        rdata_nxt = '0;
      end
    endcase
    // merge the new byte with its partner from the other palette half
    pair = s1_lsb_r ? {s1_wdata_r, rd.pal_even} : {rd.pal_odd, s1_wdata_r};
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    if (cvalid_nxt && !pair[PAIR_BLACK_BIT]) begin
      red_nxt   = expand5(pair[14:10]);
      green_nxt = expand5(pair[9:5]);
      blue_nxt  = expand5(pair[4:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      rdata_r  <= rdata_nxt;
      cvalid_r <= cvalid_nxt;
      cidx_r   <= cvalid_nxt ? s1_idx_r : '0;
      red_r    <= red_nxt;
      green_r  <= green_nxt;
      blue_r   <= blue_nxt;
      nmi_r    <= s1_nmi_r;
    end
  end

  assign out_valid       = out_v_r;
  assign out_rdata       = rdata_r;
  assign out_color_valid = cvalid_r;
  assign out_color_index = cidx_r;
  assign out_red         = red_r;
  assign out_green       = green_r;
  assign out_blue        = blue_r;
  assign out_nmi_pulse   = nmi_r;

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> in_stall)
    else $error("input transfer possible during palette clear");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> s1_v_r)
    else $error("accepted access lost before middle stage");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !out_adv) |=> s1_v_r)
    else $error("stalled middle stage dropped its access");

  a_color_no_rdata: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_color_valid) |-> ((out_rdata == '0) && !out_nmi_pulse))
    else $error("palette update carries read data or NMI");

endmodule
`default_nettype wire
